### hw/rtl/dss_pkg.sv
// shared types and constants for the delimiter string splitter
// used by dss_ctrl, dss_dpath and delimiter_string_splitter_core
package dss_pkg;

  localparam int DSS_MAX_DELIM = 8;
  localparam int DSS_CNT_W     = $clog2(DSS_MAX_DELIM + 1);
  localparam int DSS_IDX_W     = $clog2(DSS_MAX_DELIM);
  localparam int DSS_LEN_W     = 4;
  localparam int DSS_DELIM_W   = 64;
  localparam int DSS_MODE_W    = 2;
  localparam int DSS_CFG_IDX_W = 1;

  localparam logic [DSS_CFG_IDX_W-1:0] CFG_DELIM_LEN   = 1'b0;
  localparam logic [DSS_CFG_IDX_W-1:0] CFG_DELIM_BYTES = 1'b1;

  localparam logic [DSS_MODE_W-1:0] MODE_DATA     = 2'd0;
  localparam logic [DSS_MODE_W-1:0] MODE_DATA_END = 2'd1;
  localparam logic [DSS_MODE_W-1:0] MODE_END      = 2'd2;

  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_RELEASE,
    OP_END
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic can_release;
    logic full_match;
    logic rel_more;
    logic cnt_nz;
    logic mode_end;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/dss_ctrl.sv
// controller state machine for the delimiter string splitter
// depends on dss_pkg; drives commands into dss_dpath
module dss_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [dss_pkg::DSS_MODE_W-1:0] in_mode,
  input  dss_pkg::status_t               status,
  output logic                           in_ready,
  output dss_pkg::cmd_t                  cmd
);

  dss_pkg::state_t state_r;
  dss_pkg::state_t state_nxt;
  logic            has_byte;
  logic            mode_is_end;

  assign mode_is_end = (in_mode == dss_pkg::MODE_END) || (in_mode[1] == 1'b1);
  assign has_byte    = !mode_is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dss_pkg::ST_IDLE: begin
        if (in_valid && !status.len_zero) begin
          state_nxt = has_byte ? dss_pkg::ST_SCAN : dss_pkg::ST_FLUSH;
        end
      end
      dss_pkg::ST_SCAN: begin
        if (!status.can_release) begin
          if (!status.full_match || status.out_free) begin
            state_nxt = status.mode_end ? dss_pkg::ST_FLUSH : dss_pkg::ST_IDLE;
          end
        end
      end
      dss_pkg::ST_FLUSH: begin
        if (status.out_free && !status.cnt_nz) begin
          state_nxt = dss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dss_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = dss_pkg::OP_NONE;
    cmd.last = 1'b0;
    case (state_r)
      dss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = status.len_zero ? dss_pkg::OP_CLEAR : dss_pkg::OP_LOAD;
        end
      end
      dss_pkg::ST_SCAN: begin
        if (status.out_free) begin
          if (status.can_release) begin
            cmd.op   = dss_pkg::OP_RELEASE;
            cmd.last = !status.rel_more;
          end else if (status.full_match) begin
            cmd.op   = dss_pkg::OP_END;
            cmd.last = !status.mode_end;
          end
        end
      end
      dss_pkg::ST_FLUSH: begin
        if (status.out_free) begin
          if (status.cnt_nz) begin
            cmd.op = dss_pkg::OP_RELEASE;
          end else begin
            cmd.op   = dss_pkg::OP_END;
            cmd.last = 1'b1;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/dss_dpath.sv
// datapath for the delimiter string splitter: config, held bytes, match, output register
// depends on dss_pkg; commanded by dss_ctrl
module dss_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dss_pkg::DSS_CFG_IDX_W-1:0] cfg_index,
  input  logic [dss_pkg::DSS_DELIM_W-1:0] cfg_wdata,
  input  logic [dss_pkg::DSS_MODE_W-1:0]  in_mode,
  input  logic [7:0]                      in_data_byte,
  input  logic                            out_stall,
  input  dss_pkg::cmd_t                   cmd,
  output dss_pkg::status_t                status,
  output logic                            out_valid,
  output logic                            out_kind,
  output logic [7:0]                      out_out_byte,
  output logic                            out_last
);

  localparam int N = dss_pkg::DSS_MAX_DELIM;

  logic [dss_pkg::DSS_LEN_W-1:0]   delim_len_r;
  logic [dss_pkg::DSS_DELIM_W-1:0] delim_bytes_r;
  logic [7:0]                      held_r [N];
  logic [dss_pkg::DSS_CNT_W-1:0]   cnt_r;
  logic                            mode_end_r;
  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [7:0]                      out_byte_r;
  logic                            out_last_r;

  logic [dss_pkg::DSS_CNT_W-1:0]   len;
  logic [dss_pkg::DSS_CNT_W-1:0]   cnt_m1;
  logic [N-1:0]                    ok_now;
  logic [N-1:0]                    ok_sh;
  logic                            pfx_now;
  logic                            pfx_sh;
  logic                            in_end;
  logic                            emit;

  // effective length saturates at the delimiter capacity
  always_comb begin
    if (delim_len_r > dss_pkg::DSS_LEN_W'(N)) begin
      len = dss_pkg::DSS_CNT_W'(N);
    end else begin
      len = dss_pkg::DSS_CNT_W'(delim_len_r);
    end
  end

  assign cnt_m1 = cnt_r - 1'b1;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ok_now[i] = (dss_pkg::DSS_CNT_W'(i) >= cnt_r) ||
                  (held_r[i] == delim_bytes_r[i*8 +: 8]);
    end
    for (int i = 0; i < N - 1; i++) begin
      ok_sh[i] = (dss_pkg::DSS_CNT_W'(i + 1) >= cnt_r) ||
                 (held_r[i+1] == delim_bytes_r[i*8 +: 8]);
    end
    ok_sh[N-1] = 1'b1;
  end

  assign pfx_now = (cnt_r <= len) && (&ok_now);
  assign pfx_sh  = (cnt_m1 <= len) && (&ok_sh);
  assign in_end  = (in_mode == dss_pkg::MODE_END) || (in_mode[1] == 1'b1);

  always_comb begin
    status.len_zero    = (len == '0);
    status.cnt_nz      = (cnt_r != '0);
    status.can_release = (cnt_r != '0) && !pfx_now;
    status.full_match  = (cnt_r == len);
    status.rel_more    = mode_end_r || ((cnt_m1 != '0) && !pfx_sh) ||
                         (pfx_sh && (cnt_m1 == len));
    status.mode_end    = mode_end_r;
    status.out_free    = !out_valid_r || !out_stall;
  end

  assign emit = (cmd.op == dss_pkg::OP_RELEASE) || (cmd.op == dss_pkg::OP_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r   <= dss_pkg::DSS_LEN_W'(1);
      delim_bytes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dss_pkg::CFG_DELIM_LEN:   delim_len_r   <= cfg_wdata[dss_pkg::DSS_LEN_W-1:0];
        dss_pkg::CFG_DELIM_BYTES: delim_bytes_r <= cfg_wdata;
        default: delim_len_r <= delim_len_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      mode_end_r <= 1'b0;
    end else begin
      case (cmd.op)
        dss_pkg::OP_LOAD: begin
          mode_end_r <= (in_mode != dss_pkg::MODE_DATA);
          if (!in_end && (cnt_r < dss_pkg::DSS_CNT_W'(N))) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        dss_pkg::OP_CLEAR:   cnt_r <= '0;
        dss_pkg::OP_RELEASE: cnt_r <= cnt_m1;
        dss_pkg::OP_END:     cnt_r <= '0;
        default:             cnt_r <= cnt_r;
      endcase
    end
  end

  // held bytes: append at the fill point, shift down on release
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if ((cmd.op == dss_pkg::OP_LOAD) && !in_end &&
          (cnt_r < dss_pkg::DSS_CNT_W'(N)) &&
          (cnt_r[dss_pkg::DSS_IDX_W-1:0] == dss_pkg::DSS_IDX_W'(i))) begin
        held_r[i] <= in_data_byte;
      end else if ((cmd.op == dss_pkg::OP_RELEASE) && (i < N - 1)) begin
        held_r[i] <= held_r[(i < N - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_last_r <= cmd.last;
      if (cmd.op == dss_pkg::OP_RELEASE) begin
        out_kind_r <= dss_pkg::KIND_CONTENT;
        out_byte_r <= held_r[0];
      end else begin
        out_kind_r <= dss_pkg::KIND_END;
        out_byte_r <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_out_byte = out_byte_r;
  assign out_last     = out_last_r;

endmodule

### hw/rtl/delimiter_string_splitter_core.sv
// the first result of an item comes from ST_SCAN or ST_FLUSH, after the accept in ST_IDLE
// a new item is accepted only in ST_IDLE, not while the last one is scanned or flushed; a
//   byte that ends without a full match passes a decision step in ST_SCAN with no result
// results leave one per cycle through the output register while out_stall is low, the rate set by the release loop
// reset: synchronous active-low rst_n clears held count, state and output valid;
//   delimiter length resets to 1, delimiter bytes to zero
module delimiter_string_splitter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dss_pkg::DSS_CFG_IDX_W-1:0] cfg_index,
  input  logic [dss_pkg::DSS_DELIM_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dss_pkg::DSS_MODE_W-1:0]    in_mode,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic [7:0]                        out_out_byte,
  output logic                              out_last
);

  dss_pkg::cmd_t    cmd;
  dss_pkg::status_t status;
  logic             in_ready;
  logic             ctrl_valid;

  assign in_stall   = !in_ready;
  assign ctrl_valid = in_valid;

  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ctrl_valid),
    .in_mode  (in_mode),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dss_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

endmodule
